### design/crc32tc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crc32tc_pkg;

    localparam int CRC_W  = 32;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 2;

    localparam logic [CRC_W-1:0] CRC_REFLECTED_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_ALL_ONES       = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_MARK_BIT       = 32'h8000_0000;
    localparam logic [CRC_W-1:0] TYPE_FLOOR_RESET   = 32'd256;

    localparam logic [ADDR_W-1:0] REG_TYPE_FLOOR = 2'd0;

    // Reflected bitwise step for one byte, built as eight shift-and-XOR stages.
    function automatic logic [CRC_W-1:0] crc_byte_step(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_REFLECTED_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### design/crc32tc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module crc32tc_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [crc32tc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [crc32tc_pkg::CRC_W-1:0]    pwdata,
    output logic      [crc32tc_pkg::CRC_W-1:0]    prdata,
    output logic                                  pready,
    output logic      [crc32tc_pkg::CRC_W-1:0]    type_floor
);
    import crc32tc_pkg::*;

    logic [CRC_W-1:0] type_floor_reg;
    logic [CRC_W-1:0] type_floor_next;
    logic             write_hit;

    assign pready    = 1'b1;
    assign write_hit = psel && penable && pwrite && (paddr == REG_TYPE_FLOOR);

    always_comb
    begin
        type_floor_next = type_floor_reg;
        if (write_hit)
        begin
            type_floor_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_floor_reg <= TYPE_FLOOR_RESET;
        end
        else
        begin
            type_floor_reg <= type_floor_next;
        end
    end

    assign prdata     = (paddr == REG_TYPE_FLOOR) ? type_floor_reg : '0;
    assign type_floor = type_floor_reg;

endmodule

`default_nettype wire

### design/crc32tc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module crc32tc_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [crc32tc_pkg::CRC_W-1:0]    type_floor,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [crc32tc_pkg::BYTE_W-1:0]   data_byte,
    input  wire logic                             first,
    input  wire logic                             last,
    input  wire logic [crc32tc_pkg::CRC_W-1:0]    seed,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [crc32tc_pkg::CRC_W-1:0]    checksum
);
    import crc32tc_pkg::*;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [BYTE_W-1:0] s1_data_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;
    logic [CRC_W-1:0]  s1_seed_reg;

    logic [CRC_W-1:0]  running_crc_reg;
    logic [CRC_W-1:0]  running_crc_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CRC_W-1:0]  checksum_reg;
    logic [CRC_W-1:0]  checksum_next;

    logic              s1_advance;
    logic              in_take;
    logic [CRC_W-1:0]  crc_start;
    logic [CRC_W-1:0]  crc_updated;
    logic [CRC_W-1:0]  crc_final;

    // A byte that is not last leaves no result, so it never waits on the output side.
    assign s1_advance = s1_valid_reg &&
                        (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_take    = in_valid && in_ready;

    assign crc_start   = s1_first_reg ? (s1_seed_reg ^ CRC_ALL_ONES) : running_crc_reg;
    assign crc_updated = crc_byte_step(crc_start, s1_data_reg);
    assign crc_final   = crc_updated ^ CRC_ALL_ONES;

    always_comb
    begin
        s1_valid_next    = s1_valid_reg;
        running_crc_next = running_crc_reg;
        out_valid_next   = out_valid_reg;
        checksum_next    = checksum_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (s1_advance)
        begin
            running_crc_next = crc_updated;
            s1_valid_next    = 1'b0;
            if (s1_last_reg)
            begin
                out_valid_next = 1'b1;
                checksum_next  = (crc_final < type_floor) ?
                                 (crc_final | CRC_MARK_BIT) : crc_final;
            end
        end

        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            running_crc_reg <= CRC_ALL_ONES;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            running_crc_reg <= running_crc_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg  <= data_byte;
            s1_first_reg <= first;
            s1_last_reg  <= last;
            s1_seed_reg  <= seed;
        end
        checksum_reg <= checksum_next;
    end

    assign out_valid = out_valid_reg;
    assign checksum  = checksum_reg;

endmodule

`default_nettype wire

### design/crc32_type_checksum_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial reflected CRC-32 (polynomial 0x04C11DB7) with a floor marker. Each input
// transaction carries one byte; first loads the running CRC from seed XOR all ones, and
// last makes the block emit one checksum transaction holding the CRC XOR all ones, with
// bit 31 set when that value is below the type_floor register (APB offset 0, reset 256).
// The block takes one byte per cycle: the byte update is a single eight-stage XOR network
// between the input register and the running CRC register, and the checksum is registered
// as the last byte leaves the input register. Bytes keep flowing while a checksum waits in
// the output register; only a last byte stalls if the previous checksum has not been taken.
// Write type_floor only while no buffer is in flight.
module crc32_type_checksum_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [crc32tc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [crc32tc_pkg::CRC_W-1:0]    pwdata,
    output logic      [crc32tc_pkg::CRC_W-1:0]    prdata,
    output logic                                  pready,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [crc32tc_pkg::BYTE_W-1:0]   data_byte,
    input  wire logic                             first,
    input  wire logic                             last,
    input  wire logic [crc32tc_pkg::CRC_W-1:0]    seed,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [crc32tc_pkg::CRC_W-1:0]    checksum
);
    import crc32tc_pkg::*;

    logic [CRC_W-1:0] type_floor;

    crc32tc_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .type_floor (type_floor)
    );

    crc32tc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .type_floor (type_floor),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .first      (first),
        .last       (last),
        .seed       (seed),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .checksum   (checksum)
    );

endmodule

`default_nettype wire
